### sv/binary_node_record_tokenizer_unit_defines.svh
// Assertion macros shared by the tokenizer modules.
`ifndef BINARY_NODE_RECORD_TOKENIZER_UNIT_DEFINES_SVH
`define BINARY_NODE_RECORD_TOKENIZER_UNIT_DEFINES_SVH

// Checks that a condition implies a consequence at the same edge.
`define BNRT_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies a consequence at the next edge.
`define BNRT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

### sv/bnrt_pkg.sv
package bnrt_pkg;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_VERSION,
		PH_ENDOFS,
		PH_COUNT,
		PH_PLEN,
		PH_NAMELEN,
		PH_NAME,
		PH_PTYPE,
		PH_LEN4,
		PH_ARR,
		PH_PAYLOAD,
		PH_SENTINEL
	} phase_t;

	typedef enum logic [2:0] {
		EV_BEGIN = 3'd0,
		EV_PROP  = 3'd1,
		EV_END   = 3'd2,
		EV_DONE  = 3'd3,
		EV_ERROR = 3'd4
	} event_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_PAST   = 3'd1,
		ERR_BEHIND = 3'd2,
		ERR_DEEP   = 3'd3,
		ERR_EMPTY  = 3'd4,
		ERR_EARLY  = 3'd5
	} error_code_t;

	localparam int unsigned VERSION_WIDE = 7500;
	localparam int unsigned MAX_EVENTS   = 3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  depth;
		logic [7:0]  ptype;
		logic [31:0] start;
		logic [31:0] span;
		logic [31:0] count;
		logic [2:0]  err;
		logic        last;
	} event_t;

	typedef struct packed {
		logic [1:0] num;
		event_t     ev0;
		event_t     ev1;
		event_t     ev2;
	} bundle_t;

	function automatic event_t mk_event(logic [2:0] kind, logic [4:0] depth,
		logic [7:0] ptype, logic [31:0] start, logic [31:0] span, logic [31:0] count,
		logic [2:0] err);
		event_t e;
		e.kind = kind;
		e.depth = depth;
		e.ptype = ptype;
		e.start = start;
		e.span = span;
		e.count = count;
		e.err = err;
		e.last = 1'b0;
		return e;
	endfunction

endpackage

### sv/bnrt_front.sv
module bnrt_front #(
	parameter int MAX_DEPTH    = 16,
	parameter int HEADER_BYTES = 23,
	parameter int OFFSET_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        file_length,
	input  logic               in_valid,
	input  logic [7:0]         data_byte,
	output logic               busy,
	output bnrt_pkg::bundle_t  bundle,
	output logic               bundle_valid
);
	import bnrt_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic [31:0]   pos_q;
	phase_t        phase_q;
	logic [3:0]    fcnt_q;
	logic [63:0]   acc_q;
	logic          wide_q;
	logic [63:0]   stack_q [MAX_DEPTH];
	logic [DW-1:0] depth_q;
	logic [31:0]   props_q;
	logic [31:0]   left_q;
	logic [31:0]   count_q;
	logic [63:0]   top_end_q;
	logic          fin_q;

	phase_t        phase_d;
	logic [3:0]    fcnt_d;
	logic [63:0]   acc_d;
	logic          wide_d;
	logic [DW-1:0] depth_d;
	logic [31:0]   props_d;
	logic [31:0]   left_d;
	logic [31:0]   count_d;
	logic          fin_d;
	logic          push_stack;
	logic [63:0]   push_val;
	bundle_t       b;

	logic [31:0] pos1;
	logic [3:0]  wbytes;
	logic [63:0] acc_w;
	logic [63:0] acc_a;
	logic [4:0]  cur_depth;
	logic        do_payload;
	logic        do_done;
	logic        do_next;
	logic        do_tail;
	logic        do_close;
	logic        do_child;
	logic [63:0] pend_top;
	logic [DW-1:0] depth_after;

	assign busy = 1'b0;
	assign pos1 = pos_q + 32'd1;
	assign wbytes = wide_q ? 4'd8 : 4'd4;
	assign acc_w = acc_q | (64'(data_byte) << {fcnt_q[2:0], 3'b000});
	assign acc_a = ((fcnt_q[1:0] == 2'd0) ? {acc_q[63:56], 56'd0} : acc_q)
		| (64'(data_byte) << {fcnt_q[1:0], 3'b000});
	assign cur_depth = (depth_q == '0) ? 5'd0 : 5'(depth_q - 1'b1);

	// The top-of-stack end offset is kept in a register so that the stack itself
	// is only read at one address that depends on the depth after a pop.
	always_comb begin
		phase_t ph;
		logic [31:0] pl;
		logic [DW-1:0] dd;
		logic [63:0] te;
		ph = phase_q;
		phase_d = phase_q;
		fcnt_d = fcnt_q;
		acc_d = acc_q;
		wide_d = wide_q;
		depth_d = depth_q;
		props_d = props_q;
		left_d = left_q;
		count_d = count_q;
		fin_d = fin_q;
		push_stack = 1'b0;
		push_val = acc_w;
		b = '0;
		do_payload = 1'b0;
		do_done = 1'b0;
		do_next = 1'b0;
		do_tail = 1'b0;
		do_close = 1'b0;
		do_child = 1'b0;
		pl = 32'd0;
		dd = depth_q;
		te = top_end_q;
		if (in_valid && !fin_q) begin
			if (phase_q == PH_HEADER && pos_q >= 32'(HEADER_BYTES)) begin
				ph = PH_VERSION;
				fcnt_d = 4'd0;
				acc_d = 64'd0;
			end
			unique case (ph)
				PH_HEADER: begin
				end
				PH_VERSION: begin
					acc_d = acc_w;
					fcnt_d = fcnt_d + 4'd1;
					if (fcnt_q == 4'd3) begin
						wide_d = acc_w >= 64'(VERSION_WIDE);
						do_child = 1'b1;
					end
					phase_d = PH_VERSION;
				end
				PH_ENDOFS: begin
					acc_d = acc_w;
					fcnt_d = fcnt_q + 4'd1;
					if (fcnt_q + 4'd1 >= wbytes) begin
						if (acc_w == 64'd0) begin
							fin_d = 1'b1;
							if (depth_q != '0) begin
								b.num = 2'd1;
								b.ev0 = mk_event(EV_ERROR, 5'(depth_q), 8'd0, 32'd0, 32'd0,
									32'd0, ERR_EMPTY);
							end else begin
								b.num = 2'd1;
								b.ev0 = mk_event(EV_DONE, 5'd0, 8'd0, 32'd0, 32'd0, 32'd0,
									ERR_NONE);
							end
						end else if (acc_w > 64'(file_length) ||
							(OFFSET_BITS < 64 && (acc_w >> (OFFSET_BITS % 64)) != 64'd0)) begin
							fin_d = 1'b1;
							b.num = 2'd1;
							b.ev0 = mk_event(EV_ERROR, 5'(depth_q), 8'd0, 32'd0, 32'd0, 32'd0,
								ERR_PAST);
						end else if (acc_w < 64'(pos1)) begin
							fin_d = 1'b1;
							b.num = 2'd1;
							b.ev0 = mk_event(EV_ERROR, 5'(depth_q), 8'd0, 32'd0, 32'd0, 32'd0,
								ERR_BEHIND);
						end else if (depth_q >= DW'(MAX_DEPTH)) begin
							fin_d = 1'b1;
							b.num = 2'd1;
							b.ev0 = mk_event(EV_ERROR, 5'(depth_q), 8'd0, 32'd0, 32'd0, 32'd0,
								ERR_DEEP);
						end else begin
							push_stack = 1'b1;
							depth_d = depth_q + 1'b1;
							te = acc_w;
							phase_d = PH_COUNT;
							fcnt_d = 4'd0;
							acc_d = 64'd0;
						end
					end
				end
				PH_COUNT: begin
					acc_d = acc_w;
					fcnt_d = fcnt_q + 4'd1;
					if (fcnt_q + 4'd1 >= wbytes) begin
						count_d = (acc_w[63:32] != 32'd0) ? 32'hFFFF_FFFF : acc_w[31:0];
						props_d = count_d;
						phase_d = PH_PLEN;
						fcnt_d = 4'd0;
						acc_d = 64'd0;
					end
				end
				PH_PLEN: begin
					acc_d = acc_w;
					fcnt_d = fcnt_q + 4'd1;
					if (fcnt_q + 4'd1 >= wbytes) phase_d = PH_NAMELEN;
				end
				PH_NAMELEN: begin
					b.num = 2'd1;
					b.ev0 = mk_event(EV_BEGIN, cur_depth, 8'd0, pos1, 32'(data_byte), count_q,
						ERR_NONE);
					if (data_byte == 8'd0) begin
						do_next = 1'b1;
					end else begin
						left_d = 32'(data_byte);
						phase_d = PH_NAME;
					end
				end
				PH_NAME: begin
					left_d = left_q - 32'd1;
					if (left_d == 32'd0) do_next = 1'b1;
				end
				PH_PTYPE: begin
					priority case (data_byte)
						"Y": begin pl = 32'd2; do_payload = 1'b1; end
						"C": begin pl = 32'd1; do_payload = 1'b1; end
						"I", "F": begin pl = 32'd4; do_payload = 1'b1; end
						"D", "L": begin pl = 32'd8; do_payload = 1'b1; end
						"R", "S": begin
							phase_d = PH_LEN4;
							fcnt_d = 4'd0;
							acc_d = 64'd0;
						end
						"b", "f", "d", "l", "i": begin
							phase_d = PH_ARR;
							fcnt_d = 4'd0;
							acc_d = 64'd0;
						end
						default: begin
							do_payload = 1'b1;
							pl = 32'd0;
						end
					endcase
				end
				PH_LEN4: begin
					acc_d = acc_w;
					fcnt_d = fcnt_q + 4'd1;
					if (fcnt_q == 4'd3) begin
						pl = acc_w[31:0];
						do_payload = 1'b1;
					end
				end
				PH_ARR: begin
					acc_d = acc_a;
					fcnt_d = fcnt_q + 4'd1;
					if (fcnt_q == 4'd11) begin
						pl = acc_a[31:0];
						do_payload = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					left_d = left_q - 32'd1;
					if (left_d == 32'd0) do_done = 1'b1;
				end
				PH_SENTINEL: begin
					left_d = left_q - 32'd1;
					if (left_d == 32'd0) do_close = 1'b1;
				end
				default: phase_d = PH_HEADER;
			endcase
			if (ph == PH_HEADER) phase_d = PH_HEADER;
			if (do_payload) begin
				b.num = 2'd1;
				b.ev0 = mk_event(EV_PROP, cur_depth, data_byte, pos1, pl, 32'd0, ERR_NONE);
				if (phase_q == PH_LEN4 || phase_q == PH_ARR)
					b.ev0.ptype = acc_q[63:56];
				if (pl == 32'd0) begin
					do_done = 1'b1;
				end else begin
					left_d = pl;
					phase_d = PH_PAYLOAD;
				end
			end
			if (do_done) begin
				if (props_q != 32'd0) props_d = props_q - 32'd1;
				do_next = 1'b1;
			end
			if (do_next) begin
				if (props_d != 32'd0) phase_d = PH_PTYPE;
				else do_tail = 1'b1;
			end
			if (do_tail) begin
				if (64'(pos1) < te) do_child = 1'b1;
				else do_close = 1'b1;
			end
		end
		// Close and child-loop steps are resolved with the end offset of the record left on top after any pop.
		dd = depth_d;
		if (do_close) begin
			if (depth_q != '0) dd = depth_q - 1'b1;
			depth_d = dd;
			b.ev0 = (b.num == 2'd0) ? mk_event(EV_END, 5'(dd), 8'd0, 32'd0, 32'd0, 32'd0,
				ERR_NONE) : b.ev0;
			if (b.num == 2'd1) begin
				b.ev1 = mk_event(EV_END, 5'(dd), 8'd0, 32'd0, 32'd0, 32'd0, ERR_NONE);
				b.num = 2'd2;
			end else begin
				b.num = 2'd1;
			end
			te = (dd == '0) ? 64'd0 : stack_q[SW'(dd - 1'b1)];
			do_child = 1'b1;
		end
		if (do_child && in_valid && !fin_q) begin
			if (dd == '0) begin
				if (pos1 >= file_length) begin
					fin_d = 1'b1;
					unique case (b.num)
						2'd0: b.ev0 = mk_event(EV_ERROR, 5'd0, 8'd0, 32'd0, 32'd0, 32'd0,
							ERR_EARLY);
						2'd1: b.ev1 = mk_event(EV_ERROR, 5'd0, 8'd0, 32'd0, 32'd0, 32'd0,
							ERR_EARLY);
						default: b.ev2 = mk_event(EV_ERROR, 5'd0, 8'd0, 32'd0, 32'd0, 32'd0,
							ERR_EARLY);
					endcase
					b.num = b.num + 2'd1;
				end else begin
					phase_d = PH_ENDOFS;
					fcnt_d = 4'd0;
					acc_d = 64'd0;
				end
			end else if (64'(pos1) + 64'(wide_d ? 5'd25 : 5'd13) < te) begin
				phase_d = PH_ENDOFS;
				fcnt_d = 4'd0;
				acc_d = 64'd0;
			end else begin
				phase_d = PH_SENTINEL;
				left_d = 32'(wide_d ? 5'd25 : 5'd13);
			end
		end
		pend_top = te;
		depth_after = depth_d;
		if (phase_d == PH_PTYPE && in_valid && !fin_q && phase_q == PH_PTYPE)
			acc_d = {data_byte, acc_d[55:0]};
		if ((phase_d == PH_LEN4 || phase_d == PH_ARR) && phase_q == PH_PTYPE)
			acc_d = {data_byte, 56'd0};
		unique case (b.num)
			2'd1: b.ev0.last = 1'b1;
			2'd2: b.ev1.last = 1'b1;
			2'd3: b.ev2.last = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_HEADER;
			fcnt_q <= '0;
			acc_q <= '0;
			wide_q <= 1'b0;
			depth_q <= '0;
			props_q <= '0;
			left_q <= '0;
			count_q <= '0;
			top_end_q <= '0;
			fin_q <= 1'b0;
			bundle_valid <= 1'b0;
		end else begin
			bundle_valid <= 1'b0;
			if (in_valid && !fin_q) begin
				pos_q <= pos1;
				phase_q <= phase_d;
				fcnt_q <= fcnt_d;
				acc_q <= acc_d;
				wide_q <= wide_d;
				depth_q <= depth_after;
				props_q <= props_d;
				left_q <= left_d;
				count_q <= count_d;
				top_end_q <= pend_top;
				fin_q <= fin_d;
				bundle_valid <= b.num != 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_stack && in_valid && !fin_q) stack_q[SW'(depth_q)] <= push_val;
		bundle <= b;
	end

	`include "binary_node_record_tokenizer_unit_defines.svh"
	`BNRT_ASSERT_IMPL(a_depth_bound, clk, arst_n, 1'b1, depth_q <= DW'(MAX_DEPTH), "depth overflow")
	`BNRT_ASSERT_NEXT(a_fin_sticky, clk, arst_n, fin_q, fin_q, "finished cleared")
	`BNRT_ASSERT_NEXT(a_fin_quiet, clk, arst_n, fin_q, !bundle_valid, "event after finish")
endmodule

### sv/bnrt_back.sv
module bnrt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bnrt_pkg::bundle_t bundle,
	input  logic              bundle_valid,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output bnrt_pkg::event_t  head
);
	import bnrt_pkg::*;

	localparam int DEPTH = 8;

	event_t     mem_q [DEPTH];
	logic [2:0] rd_q;
	logic [2:0] wr_q;
	logic [3:0] cnt_q;
	logic       deq;
	logic [3:0] cnt_d;
	logic [3:0] held;

	assign empty = cnt_q == 4'd0;
	assign deq = pop && !empty;
	// Room for a full bundle of three words remains whenever a byte is taken.
	assign held = cnt_q + (bundle_valid ? 4'(bundle.num) : 4'd0);
	assign full = held > 4'(DEPTH - MAX_EVENTS);
	assign head = mem_q[rd_q];
	assign cnt_d = held - (deq ? 4'd1 : 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (deq) rd_q <= rd_q + 3'd1;
			if (bundle_valid) wr_q <= wr_q + 3'(bundle.num);
		end
	end

	always_ff @(posedge clk) begin
		if (bundle_valid) begin
			mem_q[wr_q] <= bundle.ev0;
			if (bundle.num >= 2'd2) mem_q[wr_q + 3'd1] <= bundle.ev1;
			if (bundle.num == 2'd3) mem_q[wr_q + 3'd2] <= bundle.ev2;
		end
	end

	`include "binary_node_record_tokenizer_unit_defines.svh"
	`BNRT_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= 4'(DEPTH), "queue overflow")
	`BNRT_ASSERT_NEXT(a_pop_moves, clk, arst_n, deq && !bundle_valid, cnt_q == $past(cnt_q) - 4'd1, "pop lost")
endmodule

### sv/binary_node_record_tokenizer_unit.sv
// Channel  | Handshake               | Payload
// input    | push / full             | data_byte
// result   | empty / pop             | event_kind .. last_event
// config   | cfg_valid / cfg_ready   | cfg_data (file_length)
// One byte is taken per cycle while full is low; each byte yields zero to three words.
// A word passes through the bundle register and then the result queue before it is on the result ports.
// full rises when the result queue, with the words still on their way, has room for
// fewer than three more.
// Reset clears all control state; the end offset stack needs no clearing.
module binary_node_record_tokenizer_unit #(
	parameter int MAX_DEPTH    = 16,
	parameter int HEADER_BYTES = 23,
	parameter int OFFSET_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_kind,
	output logic [4:0]  nesting_depth,
	output logic [7:0]  property_type,
	output logic [31:0] start_offset,
	output logic [31:0] span_length,
	output logic [31:0] property_count,
	output logic [2:0]  error_code,
	output logic        last_event,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import bnrt_pkg::*;

	logic [31:0] file_length_q;
	bundle_t     bundle;
	logic        bundle_valid;
	logic        busy;
	event_t      head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) file_length_q <= '0;
		else if (cfg_valid && cfg_ready) file_length_q <= cfg_data;
	end

	bnrt_front #(
		.MAX_DEPTH(MAX_DEPTH),
		.HEADER_BYTES(HEADER_BYTES),
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.file_length(file_length_q),
		.in_valid(push && !full && !busy),
		.data_byte(data_byte),
		.busy(busy),
		.bundle(bundle),
		.bundle_valid(bundle_valid)
	);

	logic q_full;

	bnrt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.bundle(bundle),
		.bundle_valid(bundle_valid),
		.full(q_full),
		.empty(empty),
		.pop(pop),
		.head(head)
	);

	assign full = q_full || busy;
	assign event_kind = head.kind;
	assign nesting_depth = head.depth;
	assign property_type = head.ptype;
	assign start_offset = head.start;
	assign span_length = head.span;
	assign property_count = head.count;
	assign error_code = head.err;
	assign last_event = head.last;
endmodule
